### rtl/core/rodl_pkg.sv
// Shared types and constants for the relay on/off duration limiter.
package rodl_pkg;

  // Operation codes carried by a command request
  typedef enum logic [1:0] {
    OP_CHECK_OFF  = 2'd0,
    OP_REQUEST_ON = 2'd1,
    OP_FORCE_OFF  = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_ON_MS   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_NEXT_ON_MS    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESTART_AFTER = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_OFF_MS  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NEXT_OFF_MS   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LEVEL  = 3'd5;

  // Wait after power-up before the first start, ms
  localparam logic [31:0] POWER_UP_WAIT_MS = 32'd60000;
  // Start count saturation value
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Command request payload
  typedef struct packed {
    op_t         operation;
    logic [31:0] now_ms;
  } cmd_t;

  // Result payload
  typedef struct packed {
    logic        relay_on;
    logic        relay_drive;
    logic        switched;
    logic [15:0] start_count;
    logic [31:0] on_limit;
    logic [31:0] off_limit;
  } res_t;

endpackage

### rtl/core/rodl_cmd_if.sv
// Valid/ready channel carrying command requests.
interface rodl_cmd_if;
  logic            valid;
  logic            ready;
  rodl_pkg::cmd_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/rodl_res_if.sv
// Valid/ready channel carrying result requests.
interface rodl_res_if;
  logic            valid;
  logic            ready;
  rodl_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/rodl_cfg_if.sv
// Valid/ready register write channel.
interface rodl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rodl_pkg::CfgIdxW-1:0]   index;
  logic [rodl_pkg::CfgDataW-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

### rtl/core/relay_on_off_duration_limiter_unit.sv
// Relay on/off duration limiter: top level with state and result register.
//
//   channel | dir | payload                     | accepted when
//   cmd     | in  | operation, now_ms           | cmd.valid & cmd.ready
//   res     | out | relay_on .. off_limit       | res.valid & res.ready
//   cfg     | in  | index, wdata                | cfg.valid & cfg.ready
//
// One request per cycle unless stalled; its result is out the next cycle.
// The state update: two 32-bit subtracts and compares feeding the registers.
// A held result stalls cmd only while res.ready is low; taking the result
// and accepting the next request happen in the same cycle.
// rst is synchronous; both inputs report not ready while it is high.
module relay_on_off_duration_limiter_unit (
  input  logic       clk,
  input  logic       rst,
  rodl_cmd_if.sink   cmd,
  rodl_res_if.source res,
  rodl_cfg_if.sink   cfg
);
  import rodl_pkg::*;

  // Configuration registers
  logic [31:0] first_on_ms;
  logic [31:0] next_on_ms;
  logic [15:0] restart_after;
  logic [31:0] first_off_ms;
  logic [31:0] next_off_ms;
  logic        active_level;

  // Relay state
  logic        relay_state;
  logic [31:0] on_since;
  logic [31:0] off_since;
  logic [15:0] starts;
  logic [31:0] cur_on_limit;
  logic [31:0] cur_off_limit;

  logic        relay_state_next;
  logic [31:0] on_since_next;
  logic [31:0] off_since_next;
  logic [15:0] starts_next;
  logic [31:0] cur_on_limit_next;
  logic [31:0] cur_off_limit_next;
  logic        switched_next;

  logic        cmd_acc;
  logic [31:0] on_elapsed;
  logic [31:0] off_elapsed;
  logic [15:0] starts_inc;
  logic        use_first;
  res_t        res_next;

  assign cfg.ready = ~rst;
  assign cmd.ready = ~rst & (~res.valid | res.ready);
  assign cmd_acc   = cmd.valid & cmd.ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_on_ms   <= '0;
      next_on_ms    <= '0;
      restart_after <= '0;
      first_off_ms  <= '0;
      next_off_ms   <= '0;
      active_level  <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_FIRST_ON_MS:   first_on_ms   <= cfg.wdata;
        CFG_NEXT_ON_MS:    next_on_ms    <= cfg.wdata;
        CFG_RESTART_AFTER: restart_after <= cfg.wdata[15:0];
        CFG_FIRST_OFF_MS:  first_off_ms  <= cfg.wdata;
        CFG_NEXT_OFF_MS:   next_off_ms   <= cfg.wdata;
        CFG_ACTIVE_LEVEL:  active_level  <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  // Elapsed times wrap modulo 2^32
  assign on_elapsed  = cmd.data.now_ms - on_since;
  assign off_elapsed = cmd.data.now_ms - off_since;
  assign starts_inc  = (starts == COUNT_MAX) ? starts : starts + 16'd1;
  assign use_first   = (starts_inc == 16'd1) || (starts_inc > restart_after);

  // Next state for one request
  always_comb begin
    relay_state_next   = relay_state;
    on_since_next      = on_since;
    off_since_next     = off_since;
    starts_next        = starts;
    cur_on_limit_next  = cur_on_limit;
    cur_off_limit_next = cur_off_limit;
    switched_next      = 1'b0;
    case (cmd.data.operation)
      OP_CHECK_OFF: begin
        if (relay_state && (on_elapsed >= cur_on_limit)) begin
          relay_state_next = 1'b0;
          off_since_next   = cmd.data.now_ms;
          switched_next    = 1'b1;
        end
      end
      OP_REQUEST_ON: begin
        if (!relay_state && (off_elapsed >= cur_off_limit)) begin
          relay_state_next   = 1'b1;
          on_since_next      = cmd.data.now_ms;
          switched_next      = 1'b1;
          starts_next        = starts_inc;
          cur_on_limit_next  = use_first ? first_on_ms  : next_on_ms;
          cur_off_limit_next = use_first ? first_off_ms : next_off_ms;
        end
      end
      OP_FORCE_OFF: begin
        starts_next       = '0;
        cur_on_limit_next = '0;
      end
      default: ;
    endcase
  end

  // Result built from the state after the request
  always_comb begin
    res_next.relay_on    = relay_state_next;
    res_next.relay_drive = relay_state_next ? active_level : ~active_level;
    res_next.switched    = switched_next;
    res_next.start_count = starts_next;
    res_next.on_limit    = cur_on_limit_next;
    res_next.off_limit   = cur_off_limit_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      relay_state   <= 1'b0;
      on_since      <= '0;
      off_since     <= '0;
      starts        <= '0;
      cur_on_limit  <= '0;
      cur_off_limit <= POWER_UP_WAIT_MS;
    end else if (cmd_acc) begin
      relay_state   <= relay_state_next;
      on_since      <= on_since_next;
      off_since     <= off_since_next;
      starts        <= starts_next;
      cur_on_limit  <= cur_on_limit_next;
      cur_off_limit <= cur_off_limit_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd_acc) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      res.data <= res_next;
    end
  end

  // Held result always matches the live state
  a_relay_matches: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.data.relay_on == relay_state))
    else $error("held relay_on differs from relay state");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.data.start_count == starts) && (res.data.on_limit == cur_on_limit))
    else $error("held count or on limit differs from state");

  // Force off clears count and on limit without switching
  a_force_off: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && (cmd.data.operation == OP_FORCE_OFF)) |=>
      res.valid && (res.data.start_count == '0) && (res.data.on_limit == '0) &&
      !res.data.switched)
    else $error("force off did not clear count and on limit");

  // A switch to on always counts a start
  a_switch_on_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && switched_next && relay_state_next) |=> (starts != '0))
    else $error("switch on left start count at zero");

endmodule

### tb/sv/relay_on_off_duration_limiter_unit_tb.sv
// Self-checking testbench for the relay on/off duration limiter top level.
`timescale 1ns / 1ps

module relay_on_off_duration_limiter_unit_tb;
  import rodl_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int BURST_STARTS   = 20;
  localparam int MAX_REPORTS    = 10;

  // Index values past the register list; writes there must be ignored
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_HI = 3'd7;

  typedef struct {
    logic [31:0] first_on;
    logic [31:0] next_on;
    logic [15:0] restart_after;
    logic [31:0] first_off;
    logic [31:0] next_off;
    logic        active;
  } reg_set_t;

  typedef struct {
    op_t         op;
    logic [31:0] now;
    bit          pinned;
    res_t        want;
  } dir_row_t;

  typedef struct {
    bit   pinned;
    res_t val;
  } pin_t;

  typedef struct {
    cmd_t src;
    res_t want;
  } pending_t;

  logic clk;
  logic rst;

  rodl_cmd_if cmd_ch ();
  rodl_res_if res_ch ();
  rodl_cfg_if cfg_ch ();

  relay_on_off_duration_limiter_unit u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the limiter state and registers
  logic        relay_st  = 1'b0;
  logic [31:0] on_t0     = '0;
  logic [31:0] off_t0    = '0;
  logic [15:0] start_cnt = '0;
  logic [31:0] on_lim    = '0;
  logic [31:0] off_lim   = POWER_UP_WAIT_MS;
  logic [31:0] sh_first_on   = '0;
  logic [31:0] sh_next_on    = '0;
  logic [15:0] sh_restart    = '0;
  logic [31:0] sh_first_off  = '0;
  logic [31:0] sh_next_off   = '0;
  logic        sh_active     = 1'b1;

  pending_t pending_res [$];
  pin_t     pinned_res [$];
  dir_row_t dir_rows [$];

  int  bad_cnt      = 0;
  int  cmds_seen    = 0;
  int  results_seen = 0;
  int  writes_seen  = 0;
  int  settings_cnt = 0;
  int  holds_done   = 0;
  int  quiet_cycles = 0;
  bit  count_saturated = 1'b0;
  bit  no_idle      = 1'b0;
  bit  hold_off_req = 1'b0;
  logic [31:0] run_ms = '0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Next limiter state for one command; returns the result it reports
  function automatic res_t advance_relay(input cmd_t c);
    res_t r;
    logic sw;
    sw = 1'b0;
    case (c.operation)
      OP_CHECK_OFF: begin
        if (relay_st && 32'(c.now_ms - on_t0) >= on_lim) begin
          relay_st = 1'b0;
          off_t0   = c.now_ms;
          sw       = 1'b1;
        end
      end
      OP_REQUEST_ON: begin
        if (!relay_st && 32'(c.now_ms - off_t0) >= off_lim) begin
          relay_st = 1'b1;
          on_t0    = c.now_ms;
          sw       = 1'b1;
          if (start_cnt != COUNT_MAX) start_cnt = start_cnt + 16'd1;
          if (start_cnt == 16'd1 || start_cnt > sh_restart) begin
            on_lim  = sh_first_on;
            off_lim = sh_first_off;
          end else begin
            on_lim  = sh_next_on;
            off_lim = sh_next_off;
          end
        end
      end
      OP_FORCE_OFF: begin
        start_cnt = '0;
        on_lim    = '0;
      end
      default: ;
    endcase
    r.relay_on    = relay_st;
    r.relay_drive = relay_st ? sh_active : ~sh_active;
    r.switched    = sw;
    r.start_count = start_cnt;
    r.on_limit    = on_lim;
    r.off_limit   = off_lim;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_CHECK_OFF;
    if (r < 80) return OP_REQUEST_ON;
    if (r < 92) return OP_FORCE_OFF;
    return OP_UNUSED;
  endfunction

  // Time stamps cluster around the current switching threshold
  function automatic logic [31:0] pick_now(input op_t op);
    logic [31:0] mark;
    int sel;
    sel  = $urandom_range(0, 9);
    mark = (op == OP_CHECK_OFF) ? on_t0 + on_lim : off_t0 + off_lim;
    if (sel < 5) return mark + 32'($urandom_range(0, 4)) - 32'd2;
    if (sel < 8) begin
      run_ms = run_ms + 32'($urandom_range(0, 40));
      return run_ms;
    end
    if (sel == 8) return $urandom();
    return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
  endfunction

  function automatic void add_row(input op_t op, input logic [31:0] now,
                                  input bit pinned, input res_t want);
    dir_row_t row;
    row.op     = op;
    row.now    = now;
    row.pinned = pinned;
    row.want   = want;
    dir_rows.push_back(row);
  endfunction

  // Offer one command request; returns at the falling edge after acceptance
  task automatic send_cmd(input op_t op, input logic [31:0] now);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.data  = cmd_t'{op, now};
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic play_rows();
    dir_row_t row;
    pin_t pin;
    while (dir_rows.size() != 0) begin
      row = dir_rows.pop_front();
      pin.pinned = row.pinned;
      pin.val    = row.want;
      pinned_res.push_back(pin);
      send_cmd(row.op, row.now);
    end
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic wait_drained();
    cmd_ch.valid = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write all registers, then the two unmapped indexes
  task automatic load_settings(input reg_set_t s);
    logic [CfgIdxW-1:0] idx_list [8];
    logic [31:0]        val_list [8];
    idx_list = '{CFG_FIRST_ON_MS, CFG_NEXT_ON_MS, CFG_RESTART_AFTER, CFG_FIRST_OFF_MS,
                 CFG_NEXT_OFF_MS, CFG_ACTIVE_LEVEL, CFG_UNMAPPED_LO, CFG_UNMAPPED_HI};
    val_list[0] = s.first_on;
    val_list[1] = s.next_on;
    val_list[2] = {16'($urandom()), s.restart_after};
    val_list[3] = s.first_off;
    val_list[4] = s.next_off;
    val_list[5] = {31'($urandom()), s.active};
    val_list[6] = $urandom();
    val_list[7] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom();
    for (int i = 0; i < 8; i++) begin
      cfg_ch.valid = 1'b1;
      cfg_ch.index = idx_list[i];
      cfg_ch.wdata = val_list[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_ch.valid = 1'b0;
    settings_cnt++;
  endtask

  // Result receiver: random back-pressure plus one long hold-off on request
  initial begin : receiver
    int gap;
    res_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else if (!no_idle) begin
        gap = pick_gap();
        if (gap > 0) begin
          res_ch.ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      res_ch.ready = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  // Monitor: check results, record expectations, track register writes
  always @(posedge clk) begin : monitor
    pending_t p;
    pin_t     pin;
    res_t     got;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        results_seen++;
        if (got.start_count == COUNT_MAX) count_saturated = 1'b1;
        if (pending_res.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result: on %b drive %b sw %b cnt %0d on %0d off %0d",
                     $realtime, got.relay_on, got.relay_drive, got.switched,
                     got.start_count, got.on_limit, got.off_limit);
        end else begin
          p = pending_res.pop_front();
          if (got !== p.want) begin
            bad_cnt++;
            if (bad_cnt <= MAX_REPORTS) begin
              $display("%0t: mismatch for op %s now %0d", $realtime,
                       p.src.operation.name(), p.src.now_ms);
              $display("  expected on %b drive %b sw %b cnt %0d on_lim %0d off_lim %0d",
                       p.want.relay_on, p.want.relay_drive, p.want.switched,
                       p.want.start_count, p.want.on_limit, p.want.off_limit);
              $display("  actual   on %b drive %b sw %b cnt %0d on_lim %0d off_lim %0d",
                       got.relay_on, got.relay_drive, got.switched,
                       got.start_count, got.on_limit, got.off_limit);
            end
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        p.src  = cmd_ch.data;
        p.want = advance_relay(cmd_ch.data);
        if (pinned_res.size() != 0) begin
          pin = pinned_res.pop_front();
          if (pin.pinned) p.want = pin.val;
        end
        pending_res.push_back(p);
        cmds_seen++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_FIRST_ON_MS:   sh_first_on  = cfg_ch.wdata;
          CFG_NEXT_ON_MS:    sh_next_on   = cfg_ch.wdata;
          CFG_RESTART_AFTER: sh_restart   = cfg_ch.wdata[15:0];
          CFG_FIRST_OFF_MS:  sh_first_off = cfg_ch.wdata;
          CFG_NEXT_OFF_MS:   sh_next_off  = cfg_ch.wdata;
          CFG_ACTIVE_LEVEL:  sh_active    = cfg_ch.wdata[0];
          default: ;
        endcase
        writes_seen++;
      end
    end
  end

  // Watchdog: ends the run when no request moves for too long
  always @(posedge clk) begin : watchdog
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still expected",
               $realtime, pending_res.size());
      $display("relay_on_off_duration_limiter_unit_tb: errors");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    reg_set_t s;
    op_t op;
    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows under reset registers: power-up wait, unused code,
    // request while on, force off with the relay on, time wrap
    add_row(OP_CHECK_OFF,  32'd0,          1, res_t'{1'b0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd60000});
    add_row(OP_UNUSED,     32'hFFFF_FFFF,  1, res_t'{1'b0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd60000});
    add_row(OP_REQUEST_ON, 32'd59999,      1, res_t'{1'b0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd60000});
    add_row(OP_REQUEST_ON, 32'd60000,      1, res_t'{1'b1, 1'b1, 1'b1, 16'd1, 32'd0, 32'd0});
    add_row(OP_REQUEST_ON, 32'd60001,      1, res_t'{1'b1, 1'b1, 1'b0, 16'd1, 32'd0, 32'd0});
    add_row(OP_FORCE_OFF,  32'd60002,      1, res_t'{1'b1, 1'b1, 1'b0, 16'd0, 32'd0, 32'd0});
    add_row(OP_CHECK_OFF,  32'd60002,      1, res_t'{1'b0, 1'b0, 1'b1, 16'd0, 32'd0, 32'd0});
    add_row(OP_REQUEST_ON, 32'd60002,      1, res_t'{1'b1, 1'b1, 1'b1, 16'd1, 32'd0, 32'd0});
    add_row(OP_CHECK_OFF,  32'hFFFF_FFFF,  1, res_t'{1'b0, 1'b0, 1'b1, 16'd1, 32'd0, 32'd0});
    add_row(OP_REQUEST_ON, 32'd0,          1, res_t'{1'b1, 1'b1, 1'b1, 16'd2, 32'd0, 32'd0});
    add_row(OP_CHECK_OFF,  32'd0,          1, res_t'{1'b0, 1'b0, 1'b1, 16'd2, 32'd0, 32'd0});
    play_rows();

    // Directed rows with real limits and an inverted pin: limit boundaries
    // across the wrap, first/next selection and restart
    wait_drained();
    s = '{32'd100, 32'd50, 16'd2, 32'd200, 32'd30, 1'b0};
    load_settings(s);
    add_row(OP_FORCE_OFF,  32'd10,          0, '0);
    add_row(OP_REQUEST_ON, 32'hFFFF_FFF0,   0, '0);
    add_row(OP_CHECK_OFF,  32'd83,          0, '0);
    add_row(OP_CHECK_OFF,  32'd84,          0, '0);
    add_row(OP_REQUEST_ON, 32'd283,         0, '0);
    add_row(OP_REQUEST_ON, 32'd284,         0, '0);
    add_row(OP_CHECK_OFF,  32'd334,         0, '0);
    add_row(OP_REQUEST_ON, 32'd364,         0, '0);
    add_row(OP_CHECK_OFF,  32'hFFFF_FFFF,   0, '0);
    add_row(OP_UNUSED,     32'd0,           0, '0);
    play_rows();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0};
        1: s = '{32'd0, 32'd0, 16'd0, 32'd0, 32'd0, 1'b1};
        5: s = '{$urandom(), $urandom(), 16'($urandom()), $urandom(), $urandom(),
                 1'($urandom_range(0, 1))};
        default: s = '{32'($urandom_range(0, 20)), 32'($urandom_range(0, 20)),
                       16'($urandom_range(0, 6)), 32'($urandom_range(0, 20)),
                       32'($urandom_range(0, 20)), 1'($urandom_range(0, 1))};
      endcase
      wait_drained();
      load_settings(s);
      no_idle = (ph == 3);
      if (ph == 2) hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = pick_op();
        send_cmd(op, pick_now(op));
      end
    end

    // Back-to-back start and stop pairs with no idle cycles
    wait_drained();
    s = '{32'd5, 32'd3, 16'hFFFF, 32'd7, 32'd2, 1'b1};
    load_settings(s);
    no_idle = 1'b1;
    send_cmd(OP_FORCE_OFF, run_ms);
    for (int n = 0; n < BURST_STARTS; n++) begin
      run_ms = run_ms + 32'd10;
      send_cmd(OP_REQUEST_ON, run_ms);
      run_ms = run_ms + 32'd10;
      send_cmd(OP_CHECK_OFF, run_ms);
    end
    no_idle = 1'b0;
    for (int n = 0; n < 40; n++) begin
      op = pick_op();
      send_cmd(op, pick_now(op));
    end

    wait_drained();
    repeat (5) @(posedge clk);
    bad_cnt += pending_res.size();
    $display("covered %0d commands, %0d results, %0d register writes over %0d settings",
             cmds_seen, results_seen, writes_seen, settings_cnt);
    $display("long receiver hold-offs: %0d, start count saturated: %0d, mismatches: %0d",
             holds_done, count_saturated, bad_cnt);
    if (bad_cnt == 0) begin
      $display("relay_on_off_duration_limiter_unit_tb: clean");
    end else begin
      $display("relay_on_off_duration_limiter_unit_tb: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/rodl_pkg.sv
rtl/core/rodl_cmd_if.sv
rtl/core/rodl_res_if.sv
rtl/core/rodl_cfg_if.sv
rtl/core/relay_on_off_duration_limiter_unit.sv
tb/sv/relay_on_off_duration_limiter_unit_tb.sv
